FILE: design/src_pkg.sv
// ----------------------------------------------------------------------------
// src_pkg
// Shared types and codes of the segment rectangle clipper.
// ----------------------------------------------------------------------------
package src_pkg;

	// configuration register indexes
	localparam int CFG_IDX_BITS = 2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_LEFT   = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_BOTTOM = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_RIGHT  = 2'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_TOP    = 2'd3;

	// cut kinds, in pipeline order
	localparam int CUT_LEFT   = 0;
	localparam int CUT_RIGHT  = 1;
	localparam int CUT_BOTTOM = 2;
	localparam int CUT_TOP    = 3;

	// per-item control that travels beside the box
	typedef struct packed {
		logic valid;
		logic live;
		logic up;
		logic head;
	} flags_t;

endpackage

FILE: design/segment_rectangle_clipper_core.sv
// ----------------------------------------------------------------------------
// segment_rectangle_clipper_core
// Clips a fixed point segment, as a bounding box with slope and direction
// marks, against a viewport rectangle held in four registers.
// ----------------------------------------------------------------------------
// Usage
// The segment channel (seg_valid, seg_stall) carries start_x/y and end_x/y;
// the result channel (res_valid, res_stall) carries inside_res, the clipped
// box and the rising and heading marks. The viewport is written through
// cfg_we, cfg_index and cfg_data while no segment is in flight.
// One segment is taken in every cycle in which seg_stall is low. Each of the
// four cuts takes a range test, one multiply and COORD_BITS divide stages at
// one quotient bit per stage.
// The whole pipeline moves as one; when the result is held by res_stall
// every stage holds and seg_stall is raised, so nothing is lost or repeated.
// Reset clears the viewport to zero and empties the pipeline.
// ----------------------------------------------------------------------------
module segment_rectangle_clipper_core #(
	parameter int COORD_BITS = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [src_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [COORD_BITS-1:0]               cfg_data,
	input  logic                                seg_valid,
	output logic                                seg_stall,
	input  logic signed [COORD_BITS-1:0]        start_x,
	input  logic signed [COORD_BITS-1:0]        start_y,
	input  logic signed [COORD_BITS-1:0]        end_x,
	input  logic signed [COORD_BITS-1:0]        end_y,
	output logic                                res_valid,
	input  logic                                res_stall,
	output logic                                inside_res,
	output logic signed [COORD_BITS-1:0]        box_left_x,
	output logic signed [COORD_BITS-1:0]        box_low_y,
	output logic signed [COORD_BITS-1:0]        box_right_x,
	output logic signed [COORD_BITS-1:0]        box_high_y,
	output logic                                rising,
	output logic                                heading
);

	localparam int W = COORD_BITS;

	logic signed [W-1:0] left_q, bottom_q, right_q, top_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q   <= '0;
			bottom_q <= '0;
			right_q  <= '0;
			top_q    <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				src_pkg::CFG_LEFT:   left_q   <= cfg_data;
				src_pkg::CFG_BOTTOM: bottom_q <= cfg_data;
				src_pkg::CFG_RIGHT:  right_q  <= cfg_data;
				src_pkg::CFG_TOP:    top_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	logic adv;
	assign adv       = !res_valid || !res_stall;
	assign seg_stall = !adv;

	// normalise to a box
	logic                vld_s1, up_s1, head_s1;
	logic signed [W-1:0] lx_s1, ly_s1, hx_s1, hy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else if (adv) vld_s1 <= seg_valid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			lx_s1 <= (start_x <= end_x) ? start_x : end_x;
			hx_s1 <= (start_x <= end_x) ? end_x : start_x;
			ly_s1 <= (start_y <= end_y) ? start_y : end_y;
			hy_s1 <= (start_y <= end_y) ? end_y : start_y;
			if (start_x == end_x) begin
				up_s1   <= 1'b1;
				head_s1 <= start_y <= end_y;
			end else if (start_x < end_x) begin
				up_s1   <= start_y <= end_y;
				head_s1 <= 1'b1;
			end else begin
				up_s1   <= end_y <= start_y;
				head_s1 <= 1'b0;
			end
		end
	end

	src_pkg::flags_t     fl [0:4];
	logic signed [W-1:0] clx [0:4], cly [0:4], chx [0:4], chy [0:4];
	logic signed [W-1:0] bnd [0:3];

	assign fl[0]  = '{valid: vld_s1, live: 1'b1, up: up_s1, head: head_s1};
	assign clx[0] = lx_s1;
	assign cly[0] = ly_s1;
	assign chx[0] = hx_s1;
	assign chy[0] = hy_s1;
	assign bnd[0] = left_q;
	assign bnd[1] = right_q;
	assign bnd[2] = bottom_q;
	assign bnd[3] = top_q;

	for (genvar g = 0; g < 4; g++) begin : g_cut
		src_cut #(.KIND(g), .W(W)) u_cut (
			.clk       (clk),
			.arst_n    (arst_n),
			.adv       (adv),
			.bound     (bnd[g]),
			.in_flags  (fl[g]),
			.in_lx     (clx[g]),
			.in_ly     (cly[g]),
			.in_hx     (chx[g]),
			.in_hy     (chy[g]),
			.out_flags (fl[g+1]),
			.out_lx    (clx[g+1]),
			.out_ly    (cly[g+1]),
			.out_hx    (chx[g+1]),
			.out_hy    (chy[g+1])
		);
	end

	assign res_valid   = fl[4].valid;
	assign inside_res  = fl[4].live;
	assign box_left_x  = fl[4].live ? clx[4] : '0;
	assign box_low_y   = fl[4].live ? cly[4] : '0;
	assign box_right_x = fl[4].live ? chx[4] : '0;
	assign box_high_y  = fl[4].live ? chy[4] : '0;
	assign rising      = fl[4].up;
	assign heading     = fl[4].head;

	a_box_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && inside_res |-> box_left_x <= box_right_x && box_low_y <= box_high_y)
		else $error("clipped box is not ordered");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		seg_stall |-> res_valid && res_stall)
		else $error("input held without a stalled result");

	a_inside_viewport: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && inside_res |-> box_left_x >= left_q && box_right_x <= right_q
			&& box_low_y >= bottom_q && box_high_y <= top_q)
		else $error("clipped box leaves the viewport");

endmodule

FILE: design/src_cut.sv
// ----------------------------------------------------------------------------
// src_cut
// One clip boundary: range test, multiply and pipelined restoring divide,
// then the box update. KIND selects the boundary.
// ----------------------------------------------------------------------------
module src_cut #(
	parameter int KIND = 0,
	parameter int W    = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  adv,
	input  logic signed [W-1:0]   bound,
	input  src_pkg::flags_t       in_flags,
	input  logic signed [W-1:0]   in_lx,
	input  logic signed [W-1:0]   in_ly,
	input  logic signed [W-1:0]   in_hx,
	input  logic signed [W-1:0]   in_hy,
	output src_pkg::flags_t       out_flags,
	output logic signed [W-1:0]   out_lx,
	output logic signed [W-1:0]   out_ly,
	output logic signed [W-1:0]   out_hx,
	output logic signed [W-1:0]   out_hy
);

	localparam int  LAST   = W + 1;
	localparam bit  X_AXIS = (KIND == src_pkg::CUT_LEFT) || (KIND == src_pkg::CUT_RIGHT);
	localparam bit  HIGH   = (KIND == src_pkg::CUT_RIGHT) || (KIND == src_pkg::CUT_TOP);

	typedef struct packed {
		logic signed [W-1:0] lx;
		logic signed [W-1:0] ly;
		logic signed [W-1:0] hx;
		logic signed [W-1:0] hy;
	} box_t;

	typedef struct packed {
		logic live;
		logic up;
		logic head;
	} mark_t;

	logic  vld_s [0:LAST];
	mark_t mk_s  [0:LAST];
	box_t  bx_s  [0:LAST];
	logic  cut_s [0:LAST];
	logic [W-1:0] d_s [0:LAST];
	logic [W-1:0] a_s1, b_s1;
	logic [W-1:0] rem_s [1:LAST];
	logic [W-1:0] dq_s  [1:LAST];

	logic         out_vld_q;
	mark_t        out_mk_q;
	box_t         out_bx_q;

	// entry
	logic signed [W-1:0] plo, phi, olo, ohi;
	logic         keep, cut_c;
	logic [W-1:0] a_c, b_c, d_c;
	mark_t        mk_c;
	box_t         bx_c;

	always_comb begin
		bx_c = '{lx: in_lx, ly: in_ly, hx: in_hx, hy: in_hy};
		if (X_AXIS) begin
			plo = in_lx; phi = in_hx; olo = in_ly; ohi = in_hy;
		end else begin
			plo = in_ly; phi = in_hy; olo = in_lx; ohi = in_hx;
		end
		if (HIGH) begin
			keep  = plo <= bound;
			cut_c = phi > bound;
			b_c   = phi - bound;
		end else begin
			keep  = phi >= bound;
			cut_c = plo < bound;
			b_c   = bound - plo;
		end
		cut_c = cut_c && keep && in_flags.live;
		a_c   = ohi - olo;
		d_c   = phi - plo;
		mk_c  = '{live: in_flags.live && keep, up: in_flags.up, head: in_flags.head};
	end

	// division steps
	logic [W-1:0] rem_n [2:LAST];
	logic [W-1:0] dq_n  [2:LAST];

	always_comb begin
		logic [W:0] t;
		logic       ge;
		for (int k = 2; k <= LAST; k++) begin
			t  = {rem_s[k-1], dq_s[k-1][W-1]};
			ge = t >= {1'b0, d_s[k-1]};
			rem_n[k] = ge ? W'(t - {1'b0, d_s[k-1]}) : t[W-1:0];
			dq_n[k]  = {dq_s[k-1][W-2:0], ge};
		end
	end

	// box update
	logic signed [W-1:0] flo, fhi, fo_lo, fo_hi;
	box_t bx_f;

	always_comb begin
		bx_f = bx_s[LAST];
		if (X_AXIS) begin
			flo = bx_f.lx; fhi = bx_f.hx; fo_lo = bx_f.ly; fo_hi = bx_f.hy;
		end else begin
			flo = bx_f.ly; fhi = bx_f.hy; fo_lo = bx_f.lx; fo_hi = bx_f.hx;
		end
		if (cut_s[LAST]) begin
			if (mk_s[LAST].up ^ HIGH) fo_lo = fo_lo + dq_s[LAST];
			else fo_hi = fo_hi - dq_s[LAST];
			if (HIGH) fhi = bound;
			else flo = bound;
		end
		if (X_AXIS) bx_f = '{lx: flo, ly: fo_lo, hx: fhi, hy: fo_hi};
		else bx_f = '{lx: fo_lo, ly: flo, hx: fo_hi, hy: fhi};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= LAST; k++) vld_s[k] <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (adv) begin
			vld_s[0] <= in_flags.valid;
			for (int k = 1; k <= LAST; k++) vld_s[k] <= vld_s[k-1];
			out_vld_q <= vld_s[LAST];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mk_s[0]  <= mk_c;
			bx_s[0]  <= bx_c;
			cut_s[0] <= cut_c;
			d_s[0]   <= d_c;
			a_s1     <= a_c;
			b_s1     <= b_c;
			for (int k = 1; k <= LAST; k++) begin
				mk_s[k]  <= mk_s[k-1];
				bx_s[k]  <= bx_s[k-1];
				cut_s[k] <= cut_s[k-1];
				d_s[k]   <= d_s[k-1];
			end
			{rem_s[1], dq_s[1]} <= a_s1 * b_s1;
			for (int k = 2; k <= LAST; k++) begin
				rem_s[k] <= rem_n[k];
				dq_s[k]  <= dq_n[k];
			end
			out_mk_q <= mk_s[LAST];
			out_bx_q <= bx_f;
		end
	end

	assign out_flags = '{valid: out_vld_q, live: out_mk_q.live, up: out_mk_q.up,
		head: out_mk_q.head};
	assign out_lx = out_bx_q.lx;
	assign out_ly = out_bx_q.ly;
	assign out_hx = out_bx_q.hx;
	assign out_hy = out_bx_q.hy;

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Streams fixed point segments through the rectangle clipper under random
// bursts, gaps and result stalls, and checks every clipped box and its marks
// against a clip predictor kept in step with the viewport registers.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CB = 32;
	localparam int LATENCY = 1 + 4 * (CB + 3);
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int LONG_HOLD_AT = 645;
	localparam int LONG_HOLD_CYCLES = 600;

	typedef struct packed {
		logic signed [CB-1:0] sx, sy, ex, ey;
	} segment_t;

	typedef struct packed {
		logic in_vp;
		logic signed [CB-1:0] lx, ly, hx, hy;
		logic up, head;
	} clip_t;

	logic clk, arst_n;
	logic cfg_we;
	logic [src_pkg::CFG_IDX_BITS-1:0] cfg_index;
	logic [CB-1:0] cfg_data;
	logic seg_valid, seg_stall;
	logic signed [CB-1:0] start_x, start_y, end_x, end_y;
	logic res_valid, res_stall;
	logic inside_res, rising, heading;
	logic signed [CB-1:0] box_left_x, box_low_y, box_right_x, box_high_y;

	segment_rectangle_clipper_core #(.COORD_BITS(CB)) uut (.*);

	segment_t pending_segs[$];
	clip_t expected_clips[$];
	logic signed [CB-1:0] vp_left, vp_bottom, vp_right, vp_top;
	int mismatches = 0;
	int transfers_in = 0;
	int transfers_out = 0;
	int idle_cycles = 0;
	int inside_seen = 0;
	int long_left = 0;
	bit long_done = 0;
	bit sender_hold, done;
	int burst_left, gap_left, hold_count;

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	function automatic logic [63:0] scaled_step(logic [63:0] a, logic [63:0] b,
			logic [63:0] d);
		logic [127:0] p;
		p = a * b;
		return 64'(p / d);
	endfunction

	function automatic clip_t clip_segment(segment_t s);
		clip_t r;
		longint x0, y0, x1, y1, l, b, rt, t, lx, ly, hx, hy;
		logic [63:0] q;
		bit up, head, in;
		x0 = s.sx; y0 = s.sy; x1 = s.ex; y1 = s.ey;
		l = vp_left; b = vp_bottom; rt = vp_right; t = vp_top;
		in = 0;
		if (x0 == x1) begin
			lx = x0; hx = x1; up = 1;
			if (y0 <= y1) begin ly = y0; hy = y1; head = 1; end
			else begin ly = y1; hy = y0; head = 0; end
		end else if (x0 < x1) begin
			lx = x0; hx = x1; head = 1;
			if (y0 <= y1) begin ly = y0; hy = y1; up = 1; end
			else begin ly = y1; hy = y0; up = 0; end
		end else begin
			lx = x1; hx = x0; head = 0;
			if (y1 <= y0) begin ly = y1; hy = y0; up = 1; end
			else begin ly = y0; hy = y1; up = 0; end
		end
		if (hx >= l) begin
			if (lx < l) begin
				q = scaled_step(hy - ly, l - lx, hx - lx);
				if (up) ly += q; else hy -= q;
				lx = l;
			end
			if (lx <= rt) begin
				if (hx > rt) begin
					q = scaled_step(hy - ly, hx - rt, hx - lx);
					if (up) hy -= q; else ly += q;
					hx = rt;
				end
				if (hy >= b) begin
					if (ly < b) begin
						q = scaled_step(hx - lx, b - ly, hy - ly);
						if (up) lx += q; else hx -= q;
						ly = b;
					end
					if (ly <= t) begin
						if (hy > t) begin
							q = scaled_step(hx - lx, hy - t, hy - ly);
							if (up) hx -= q; else lx += q;
							hy = t;
						end
						in = 1;
					end
				end
			end
		end
		if (!in) begin lx = 0; ly = 0; hx = 0; hy = 0; end
		r.in_vp = in; r.lx = lx[CB-1:0]; r.ly = ly[CB-1:0];
		r.hx = hx[CB-1:0]; r.hy = hy[CB-1:0]; r.up = up; r.head = head;
		return r;
	endfunction

	function automatic logic [CB-1:0] pick_coord(int mode);
		case ($urandom_range(9))
			0: return {1'b1, {(CB-1){1'b0}}};
			1: return {1'b0, {(CB-1){1'b1}}};
			2: return $urandom;
			default: return mode ? CB'(signed'($urandom_range(400)) - 200) <<< 16
				: CB'(signed'($urandom_range(2000)) - 1000) <<< 8;
		endcase
	endfunction

	task automatic queue_seg(segment_t s);
		pending_segs = {pending_segs, s};
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_valid <= 0;
			{start_x, start_y, end_x, end_y} <= '0;
			burst_left <= 0;
			gap_left <= 0;
		end else begin
			if (seg_valid && !seg_stall) begin
				expected_clips = {expected_clips,
					clip_segment({start_x, start_y, end_x, end_y})};
				transfers_in <= transfers_in + 1;
			end
			if (!seg_valid || !seg_stall) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					seg_valid <= 0;
				end else if (pending_segs.size() > 0 && !sender_hold) begin
					{start_x, start_y, end_x, end_y} <= pending_segs.pop_front();
					seg_valid <= 1;
					if (burst_left == 0) begin
						burst_left <= $urandom_range(40, 1);
						gap_left <= $urandom_range(3) == 0 ? 0 : $urandom_range(6);
					end else
						burst_left <= burst_left - 1;
				end else
					seg_valid <= 0;
			end
		end
	end

	// receiver stall pattern, with one long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_stall <= 0;
			hold_count <= 0;
		end else if (long_left > 0) begin
			long_left <= long_left - 1;
			res_stall <= 1;
		end else if (!long_done && transfers_in >= LONG_HOLD_AT) begin
			long_done <= 1;
			long_left <= LONG_HOLD_CYCLES;
			res_stall <= 1;
		end else if (hold_count > 0) begin
			hold_count <= hold_count - 1;
			res_stall <= 1;
		end else if ($urandom_range(15) == 0) begin
			hold_count <= $urandom_range(8);
			res_stall <= 1;
		end else
			res_stall <= ($urandom_range(3) == 0) && transfers_in[8];
	end

	// monitor
	always @(posedge clk) begin
		clip_t exp_c, got;
		if (arst_n && res_valid && !res_stall) begin
			got = {inside_res, box_left_x, box_low_y, box_right_x, box_high_y, rising, heading};
			transfers_out <= transfers_out + 1;
			if (got.in_vp) inside_seen <= inside_seen + 1;
			if (expected_clips.size() == 0) begin
				mismatches <= mismatches + 1;
				if (mismatches < 10) $display("unexpected result %h", got);
			end else begin
				exp_c = expected_clips.pop_front();
				if (got !== exp_c) begin
					mismatches <= mismatches + 1;
					if (mismatches < 10)
						$display("mismatch: expected %h got %h", exp_c, got);
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((seg_valid && !seg_stall) || (res_valid && !res_stall) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG_LIMIT) begin
			$display("watchdog expired");
			$display("testbench NOT OK");
			$finish;
		end
	end

	task automatic write_reg(logic [src_pkg::CFG_IDX_BITS-1:0] idx, logic [CB-1:0] v);
		@(posedge clk);
		cfg_we <= 1; cfg_index <= idx; cfg_data <= v;
		@(posedge clk);
		cfg_we <= 0;
		case (idx)
			src_pkg::CFG_LEFT: vp_left = v;
			src_pkg::CFG_BOTTOM: vp_bottom = v;
			src_pkg::CFG_RIGHT: vp_right = v;
			default: vp_top = v;
		endcase
	endtask

	task automatic drain();
		wait (pending_segs.size() == 0 && !seg_valid);
		wait (expected_clips.size() == 0);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	task automatic set_viewport(logic [CB-1:0] l, logic [CB-1:0] b,
			logic [CB-1:0] r, logic [CB-1:0] t);
		drain();
		write_reg(src_pkg::CFG_LEFT, l);
		write_reg(src_pkg::CFG_BOTTOM, b);
		write_reg(src_pkg::CFG_RIGHT, r);
		write_reg(src_pkg::CFG_TOP, t);
	endtask

	initial begin
		logic [CB-1:0] mx, mn;
		int lo, hi;
		segment_t s;
		mx = {1'b0, {(CB-1){1'b1}}};
		mn = {1'b1, {(CB-1){1'b0}}};
		cfg_we = 0; cfg_index = '0; cfg_data = '0;
		vp_left = 0; vp_bottom = 0; vp_right = 0; vp_top = 0;
		sender_hold = 0; done = 0;
		arst_n = 0;
		repeat (11) @(posedge clk);
		#1 arst_n = 1;

		// directed: reset viewport is the single point at the origin
		queue_seg('{0, 0, 0, 0});
		queue_seg('{-5, -5, 5, 5});
		set_viewport(-100 <<< 16, -50 <<< 16, 100 <<< 16, 50 <<< 16);
		queue_seg('{mn, mn, mx, mx});
		queue_seg('{mx, mn, mn, mx});
		queue_seg('{mx, mx, mn, mn});
		queue_seg('{0, mn, 0, mx});
		queue_seg('{0, mx, 0, mn});
		queue_seg('{mn, 0, mx, 0});
		queue_seg('{-100 <<< 16, 50 <<< 16, -200 <<< 16, 60 <<< 16});
		queue_seg('{100 <<< 16, 0, 300 <<< 16, 0});
		queue_seg('{-300 <<< 16, -60 <<< 16, 300 <<< 16, -60 <<< 16});
		queue_seg('{1, 2, 3, 4});
		queue_seg('{200 <<< 16, 0, 300 <<< 16, 1});
		queue_seg('{-150 <<< 16, 100 <<< 16, 150 <<< 16, -100 <<< 16});
		set_viewport(10, 0, -10, 0);
		queue_seg('{-5, -5, 5, 5});
		queue_seg('{0, 0, 0, 0});
		set_viewport(mn, mn, mx, mx);
		queue_seg('{mn, mx, mx, mn});
		queue_seg('{5, 7, -9, 3});

		// random phases through several viewports
		for (int ph = 0; ph < 10; ph++) begin
			case (ph)
				0: set_viewport(mn, mn, mx, mx);
				1: set_viewport(0, 0, 0, 0);
				2: set_viewport($urandom, $urandom, $urandom, $urandom);
				default: begin
					lo = -$urandom_range(150);
					hi = $urandom_range(150);
					set_viewport(lo <<< 16, (lo / 2) <<< 16, hi <<< 16, (hi - 20) <<< 16);
				end
			endcase
			for (int i = 0; i < 155; i++) begin
				s.sx = pick_coord(ph > 2);
				s.sy = pick_coord(ph > 2);
				s.ex = $urandom_range(7) == 0 ? s.sx : pick_coord(ph > 2);
				s.ey = pick_coord(ph > 2);
				queue_seg(s);
			end
			if (ph == 6) begin
				wait (pending_segs.size() < 80);
				sender_hold = 1;
				wait (expected_clips.size() == 0 && !seg_valid);
				repeat (LATENCY + 10) @(posedge clk);
				sender_hold = 0;
			end
		end
		drain();
		done = 1;
		$display("sent %0d segments over 14 viewports, %0d results, %0d inside",
			transfers_in, transfers_out, inside_seen);
		if (mismatches == 0 && expected_clips.size() == 0)
			$display("testbench OK");
		else begin
			$display("%0d mismatches", mismatches);
			$display("testbench NOT OK");
		end
		$finish;
	end
endmodule
